// ----- design/quicksort_sorter_macros.svh -----
// ----------------------------------------------------------------------------
// quicksort_sorter assertion macros
// Shared concurrent assertion forms for the sorter checker.
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_SORTER_MACROS_SVH
`define QUICKSORT_SORTER_MACROS_SVH

// same-cycle implication, masked during reset
`define QS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define QS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// state of the ports in the cycle after reset is held
`define QS_ASSERT_RESET(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/qs_pkg.sv -----
// ----------------------------------------------------------------------------
// qs_pkg
// Types and constants shared by the quicksort sorter modules.
// ----------------------------------------------------------------------------
package qs_pkg;

    localparam int DEFAULT_MAX_ITEMS = 64;
    localparam int VALUE_W           = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_PIVOT,
        ST_SCAN,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_FINAL,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_PUSH_HI,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

endpackage

// ----- design/quicksort_sorter.sv -----
// Load: words load at one per cycle; the sort starts the cycle after the tlast word.
// Each partition of a range is bound by the single read and write port of the value
// store; results then leave through ST_EMIT_RD and ST_EMIT_LD, stalling on m_tready.
// Throughput: one set at a time; s_tready stays low until the last result is loaded.
// Reset: aresetn (synchronous, active low) empties the store, stack and output register.
// ----------------------------------------------------------------------------
// quicksort_sorter
// Collects a set of signed words, sorts them in place by Lomuto quicksort with
// an explicit range stack, then streams them out in ascending order.
// ----------------------------------------------------------------------------
module quicksort_sorter #(
    parameter int MAX_ITEMS = qs_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic signed [qs_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic signed [qs_pkg::VALUE_W-1:0]  m_tdata,   // [31:0] sorted_value
    output logic                               m_tlast,
    output logic [0:0]                         m_tuser    // [0] overflow
);

    localparam int VW    = qs_pkg::VALUE_W;
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    qs_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 ovf_reg, ovf_next;
    logic [IDX_W-1:0]     lo_reg, lo_next;
    logic [IDX_W-1:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]     p_reg, p_next;
    logic [IDX_W-1:0]     t_reg, t_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic signed [VW-1:0] pv_reg, pv_next;
    logic [VW-1:0]        vt_reg, vt_next;
    logic signed [VW-1:0] out_data_reg, out_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic [VW-1:0]        store_mem [MAX_ITEMS];
    logic [VW-1:0]        rdata_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic [VW-1:0]        wr_data;
    logic                 wr_en;

    qs_pkg::stk_ctrl_t    stk_ctrl;
    logic [IDX_W-1:0]     push_lo, push_hi, pop_lo, pop_hi;
    logic                 stk_empty;

    logic                 s_acc;
    logic                 store_full;
    logic                 value_lt;
    logic                 t_at_hi;
    logic                 emit_free;
    logic                 emit_last;
    logic                 multi;
    logic [CNT_W-1:0]     cnt_dec;
    logic [IDX_W-1:0]     cnt_m1;
    logic [IDX_W:0]       lo_inc, p_ext, p_inc, hi_ext;
    logic                 push_low_side, push_high_side;

    qs_range_stack #(
        .DEPTH (MAX_ITEMS),
        .IDX_W (IDX_W)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (stk_ctrl),
        .push_lo (push_lo),
        .push_hi (push_hi),
        .pop_lo  (pop_lo),
        .pop_hi  (pop_hi),
        .empty   (stk_empty)
    );

    assign s_tready   = (state_reg == qs_pkg::ST_LOAD);
    assign s_acc      = s_tvalid && s_tready;
    assign store_full = (cnt_reg == CNT_W'(MAX_ITEMS));
    assign value_lt   = $signed(rdata_reg) < pv_reg;
    assign t_at_hi    = (t_reg == hi_reg);
    assign emit_free  = !out_valid_reg || m_tready;
    assign cnt_dec    = cnt_reg - CNT_W'(1);
    assign cnt_m1     = cnt_dec[IDX_W-1:0];
    assign emit_last  = (k_reg == cnt_m1);
    assign multi      = (cnt_reg > CNT_W'(1));
    assign lo_inc     = {1'b0, lo_reg} + (IDX_W+1)'(1);
    assign p_ext      = {1'b0, p_reg};
    assign p_inc      = p_ext + (IDX_W+1)'(1);
    assign hi_ext     = {1'b0, hi_reg};
    assign push_low_side  = (p_ext > lo_inc);
    assign push_high_side = (p_inc < hi_ext);

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser    = out_ovf_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qs_pkg::ST_LOAD: begin
                if (s_acc && s_tlast) state_next = qs_pkg::ST_SORT_INIT;
            end
            qs_pkg::ST_SORT_INIT: begin
                state_next = multi ? qs_pkg::ST_POP : qs_pkg::ST_EMIT_RD;
            end
            qs_pkg::ST_POP: begin
                state_next = stk_empty ? qs_pkg::ST_EMIT_RD : qs_pkg::ST_POP_WAIT;
            end
            qs_pkg::ST_POP_WAIT: state_next = qs_pkg::ST_PIVOT;
            qs_pkg::ST_PIVOT:    state_next = qs_pkg::ST_SCAN;
            qs_pkg::ST_SCAN: begin
                if (value_lt)     state_next = qs_pkg::ST_SWAP_RD;
                else if (t_at_hi) state_next = qs_pkg::ST_FINAL;
            end
            qs_pkg::ST_SWAP_RD: state_next = qs_pkg::ST_SWAP_WR;
            qs_pkg::ST_SWAP_WR: begin
                state_next = t_at_hi ? qs_pkg::ST_FINAL : qs_pkg::ST_SCAN;
            end
            qs_pkg::ST_FINAL:   state_next = qs_pkg::ST_FIN_RD;
            qs_pkg::ST_FIN_RD:  state_next = qs_pkg::ST_FIN_WR;
            qs_pkg::ST_FIN_WR:  state_next = qs_pkg::ST_PUSH_HI;
            qs_pkg::ST_PUSH_HI: state_next = qs_pkg::ST_POP;
            qs_pkg::ST_EMIT_RD: begin
                if (emit_free) state_next = qs_pkg::ST_EMIT_LD;
            end
            qs_pkg::ST_EMIT_LD: begin
                state_next = emit_last ? qs_pkg::ST_LOAD : qs_pkg::ST_EMIT_RD;
            end
            default: state_next = qs_pkg::ST_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb begin
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        p_next         = p_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        pv_next        = pv_reg;
        vt_next        = vt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        rd_addr        = t_reg;
        wr_en          = 1'b0;
        wr_addr        = t_reg;
        wr_data        = rdata_reg;
        stk_ctrl       = '0;
        push_lo        = lo_reg;
        push_hi        = hi_reg;
        case (state_reg)
            qs_pkg::ST_LOAD: begin
                if (s_acc) begin
                    if (!store_full) begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_reg[IDX_W-1:0];
                        wr_data  = s_tdata;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            qs_pkg::ST_SORT_INIT: begin
                k_next = '0;
                if (multi) begin
                    stk_ctrl.push = 1'b1;
                    push_lo       = '0;
                    push_hi       = cnt_m1;
                end
            end
            qs_pkg::ST_POP: begin
                k_next       = '0;
                stk_ctrl.pop = !stk_empty;
            end
            qs_pkg::ST_POP_WAIT: begin
                lo_next = pop_lo;
                hi_next = pop_hi;
                rd_addr = pop_lo;
            end
            qs_pkg::ST_PIVOT: begin
                pv_next = $signed(rdata_reg);
                p_next  = lo_reg;
                t_next  = lo_inc[IDX_W-1:0];
                rd_addr = lo_inc[IDX_W-1:0];
            end
            qs_pkg::ST_SCAN: begin
                if (value_lt) begin
                    vt_next = rdata_reg;
                    p_next  = p_inc[IDX_W-1:0];
                    rd_addr = p_inc[IDX_W-1:0];
                end else if (!t_at_hi) begin
                    t_next  = t_reg + IDX_W'(1);
                    rd_addr = t_reg + IDX_W'(1);
                end
            end
            qs_pkg::ST_SWAP_RD: begin
                wr_en   = 1'b1;
                wr_addr = t_reg;
                wr_data = rdata_reg;
            end
            qs_pkg::ST_SWAP_WR: begin
                wr_en   = 1'b1;
                wr_addr = p_reg;
                wr_data = vt_reg;
                if (!t_at_hi) begin
                    t_next  = t_reg + IDX_W'(1);
                    rd_addr = t_reg + IDX_W'(1);
                end
            end
            qs_pkg::ST_FINAL: begin
                rd_addr = p_reg;
            end
            qs_pkg::ST_FIN_RD: begin
                wr_en   = 1'b1;
                wr_addr = lo_reg;
                wr_data = rdata_reg;
            end
            qs_pkg::ST_FIN_WR: begin
                wr_en   = 1'b1;
                wr_addr = p_reg;
                wr_data = pv_reg;
                if (push_low_side) begin
                    stk_ctrl.push = 1'b1;
                    push_lo       = lo_reg;
                    push_hi       = p_reg - IDX_W'(1);
                end
            end
            qs_pkg::ST_PUSH_HI: begin
                if (push_high_side) begin
                    stk_ctrl.push = 1'b1;
                    push_lo       = p_inc[IDX_W-1:0];
                    push_hi       = hi_reg;
                end
            end
            qs_pkg::ST_EMIT_RD: begin
                rd_addr = k_reg;
            end
            qs_pkg::ST_EMIT_LD: begin
                out_data_next  = $signed(rdata_reg);
                out_valid_next = 1'b1;
                out_last_next  = emit_last;
                out_ovf_next   = ovf_reg;
                if (emit_last) begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    // value store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= qs_pkg::ST_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        p_reg        <= p_next;
        t_reg        <= t_next;
        k_reg        <= k_next;
        pv_reg       <= pv_next;
        vt_reg       <= vt_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

endmodule

// ----- design/qs_range_stack.sv -----
// ----------------------------------------------------------------------------
// qs_range_stack
// Stack of pending subranges {lo, hi} held in a synchronous memory.
// Pop data is registered and appears in the cycle after the pop request.
// ----------------------------------------------------------------------------
module qs_range_stack #(
    parameter int DEPTH = qs_pkg::DEFAULT_MAX_ITEMS,
    parameter int IDX_W = $clog2(qs_pkg::DEFAULT_MAX_ITEMS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  qs_pkg::stk_ctrl_t  ctrl,
    input  logic [IDX_W-1:0]   push_lo,
    input  logic [IDX_W-1:0]   push_hi,
    output logic [IDX_W-1:0]   pop_lo,
    output logic [IDX_W-1:0]   pop_hi,
    output logic               empty
);

    localparam int AW   = $clog2(DEPTH);
    localparam int SP_W = $clog2(DEPTH + 1);
    localparam int EW   = 2 * IDX_W;

    logic [EW-1:0]   stack_mem [DEPTH];
    logic [EW-1:0]   rd_data_reg;
    logic [SP_W-1:0] sp_reg;
    logic [SP_W-1:0] sp_next;
    logic [SP_W-1:0] sp_dec;
    logic            can_push;

    assign sp_dec   = sp_reg - SP_W'(1);
    assign can_push = sp_reg < SP_W'(DEPTH);
    assign empty    = (sp_reg == '0);
    assign pop_lo   = rd_data_reg[EW-1:IDX_W];
    assign pop_hi   = rd_data_reg[IDX_W-1:0];

    always_comb begin
        sp_next = sp_reg;
        if (ctrl.push && can_push) begin
            sp_next = sp_reg + SP_W'(1);
        end else if (ctrl.pop && !empty) begin
            sp_next = sp_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push && can_push) begin
            stack_mem[sp_reg[AW-1:0]] <= {push_lo, push_hi};
        end
        if (ctrl.pop) begin
            rd_data_reg <= stack_mem[sp_dec[AW-1:0]];
        end
    end

endmodule

// ----- design/qs_checker.sv -----
// ----------------------------------------------------------------------------
// qs_checker
// Port-level checks on the quicksort sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "quicksort_sorter_macros.svh"

module qs_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               s_tlast,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic signed [qs_pkg::VALUE_W-1:0]  m_tdata,
    input logic                               m_tlast,
    input logic [0:0]                         m_tuser
);

    // stalled result word holds
    `QS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result word changed while stalled")

    // no output straight out of reset
    `QS_ASSERT_RESET(a_reset_idle, aclk, aresetn, !m_tvalid, "result valid after reset")

    // closing word of a set stops the input while sorting
    `QS_ASSERT_NEXT(a_sort_blocks_in, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready, "input accepted right after end of set")

    // mid-set results mean the block is still emitting
    `QS_ASSERT_NOW(a_emit_blocks_in, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "input ready during emission of a set")

endmodule

bind quicksort_sorter qs_checker u_qs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ----- sim/tb_quicksort_sorter.sv -----
// ----------------------------------------------------------------------------
// tb_quicksort_sorter
// Streams sets of signed words into the sorter and checks each sorted word,
// its tlast and its overflow flag against a quicksort predictor kept here.
// Covers single-word sets, duplicates, presorted and reversed sets, full and
// overflowing stores. Both stream sides idle at random, and there is one long
// output hold-off that backs the sorter up onto its input.
// ----------------------------------------------------------------------------
module tb_quicksort_sorter;

    localparam int STORE_DEPTH = qs_pkg::DEFAULT_MAX_ITEMS;
    localparam int ITEM_TARGET = 350;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 500;

    localparam logic signed [31:0] VMIN = 32'sh8000_0000;
    localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [31:0] value;
        bit                 last;
        bit                 ovf;
    } sorted_word_t;

    class sort_scoreboard;
        logic signed [31:0] store [STORE_DEPTH];
        int unsigned        fill;
        bit                 ovf_seen;
        sorted_word_t       sorted_q [$];
        int                 errors;

        function new();
            fill     = 0;
            ovf_seen = 0;
            errors   = 0;
        endfunction

        // Lomuto partition, first element as pivot, explicit range stack
        function void quicksort(int unsigned n);
            int unsigned        lo_q [$];
            int unsigned        hi_q [$];
            int unsigned        lo, hi, p, t;
            logic signed [31:0] pv, tmp;
            if (n >= 2) begin
                lo_q.push_back(0);
                hi_q.push_back(n - 1);
            end
            while (lo_q.size() > 0) begin
                lo = lo_q.pop_back();
                hi = hi_q.pop_back();
                if (lo >= hi || hi >= n)
                    continue;
                pv = store[lo];
                p  = lo;
                for (t = lo + 1; t <= hi; t++) begin
                    if (store[t] < pv) begin
                        p++;
                        tmp      = store[t];
                        store[t] = store[p];
                        store[p] = tmp;
                    end
                end
                tmp       = store[lo];
                store[lo] = store[p];
                store[p]  = tmp;
                if (p > lo + 1) begin
                    lo_q.push_back(lo);
                    hi_q.push_back(p - 1);
                end
                if (p + 1 < hi) begin
                    lo_q.push_back(p + 1);
                    hi_q.push_back(hi);
                end
            end
        endfunction

        function void note_word(logic signed [31:0] v, bit last);
            sorted_word_t w;
            if (fill < STORE_DEPTH) begin
                store[fill] = v;
                fill++;
            end else begin
                ovf_seen = 1;
            end
            if (last) begin
                quicksort(fill);
                for (int unsigned k = 0; k < fill; k++) begin
                    w.value = store[k];
                    w.last  = (k + 1 == fill);
                    w.ovf   = ovf_seen;
                    sorted_q.push_back(w);
                end
                fill     = 0;
                ovf_seen = 0;
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic signed [31:0] v, bit last, bit ovf);
            sorted_word_t w;
            if (sorted_q.size() == 0) begin
                report($sformatf("unexpected word %0d", v));
                return;
            end
            w = sorted_q.pop_front();
            if (v !== w.value)
                report($sformatf("tdata %0d, want %0d", v, w.value));
            if (last !== w.last)
                report($sformatf("tlast %0b, want %0b (word %0d)", last, w.last, w.value));
            if (ovf !== w.ovf)
                report($sformatf("overflow %0b, want %0b (word %0d)", ovf, w.ovf, w.value));
        endtask
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic signed [31:0]  s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic signed [31:0]  m_tdata;
    logic                m_tlast;
    logic [0:0]          m_tuser;

    sort_scoreboard sb = new();

    int unsigned words_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned cycle_count = 0;

    quicksort_sorter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_quicksort_sorter: FAIL");
            $finish;
        end
    end

    // receiver: one of four stall modes chosen at random and redrawn periodically, plus one long hold-off
    int unsigned hold_left = 0;
    bit          hold_done = 0;
    int unsigned stall_mode = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser[0]);
            if (cycle_count % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            if (!hold_done && words_sent > 120 && m_tvalid) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 9) < 3);
                    default: m_tready <= (cycle_count[2:0] != 3'd0);
                endcase
            end
        end
    end

    task automatic send_word(input logic signed [31:0] v, input bit last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(v, last);
        words_sent++;
        burst_left--;
    endtask

    task automatic send_set(input logic signed [31:0] set_q [$]);
        foreach (set_q[i])
            send_word(set_q[i], i == set_q.size() - 1);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? VMIN : VMAX;
            1, 2, 3: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)      return $urandom_range(1, 8);
        else if (r < 85) return $urandom_range(9, 24);
        else if (r < 92) return $urandom_range(25, STORE_DEPTH - 1);
        else if (r < 96) return STORE_DEPTH;
        else             return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
    endfunction

    initial begin
        logic signed [31:0] set_q [$];
        int unsigned        n;
        int unsigned        shape;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single words, extremes, pairs, duplicates, ordered sets
        send_set('{VMIN});
        send_set('{VMAX});
        send_set('{32'sd0});
        send_set('{32'sd5, -32'sd5});
        send_set('{-32'sd5, 32'sd5});
        send_set('{32'sd7, 32'sd7, 32'sd7});
        send_set('{VMAX, VMIN, 32'sd0, -32'sd1, 32'sd1});
        send_set('{-32'sd3, 32'sd0, 32'sd2, 32'sd9});
        send_set('{32'sd9, 32'sd2, 32'sd0, -32'sd3});

        while (words_sent < ITEM_TARGET) begin
            n = pick_size();
            set_q.delete();
            for (int unsigned i = 0; i < n; i++)
                set_q.push_back(pick_value());
            shape = $urandom_range(0, 9);
            if (shape == 0)
                set_q.sort();
            else if (shape == 1)
                set_q.rsort();
            send_set(set_q);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.sorted_q.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (sb.errors == 0)
            $display("tb_quicksort_sorter: PASS");
        else
            $display("tb_quicksort_sorter: FAIL");
        $finish;
    end

endmodule
